/* hw/rtl/wpsm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpsm_pkg: shared types and constants of the wearable power state machine
// Power modes, command codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package wpsm_pkg;

  typedef enum logic [1:0] {
    MODE_MONITORING = 2'd0,
    MODE_IDLE       = 2'd1,
    MODE_DORMANT    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_CANCEL = 2'd2
  } cmd_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CountW   = 8;

  localparam logic [CfgIdxW-1:0] CFG_DORMANT_ALLOWED   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_NO_FINGER_TIMEOUT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_STILL_TIMEOUT     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PROBE_WINDOW_LEN  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PROBE_INTERVAL    = 3'd4;

  localparam logic [TimeW-1:0]  RST_NO_FINGER_TIMEOUT = 32'd30000;
  localparam logic [TimeW-1:0]  RST_STILL_TIMEOUT     = 32'd300000;
  localparam logic [CountW-1:0] RST_PROBE_WINDOW_LEN  = 8'd5;
  localparam logic [TimeW-1:0]  RST_PROBE_INTERVAL    = 32'd2000;

  localparam logic [CountW-1:0] PROBE_COUNT_MAX = {CountW{1'b1}};

endpackage

/* hw/rtl/wpsm_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpsm_in_if: command channel of the wearable power state machine
// Valid/ready channel carrying one command word per handshake.
// ----------------------------------------------------------------------------
interface wpsm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] now_ms;
  logic        finger_present;
  logic        motion_seen;
  logic        woke_on_timer;

  modport source (
    output valid, command, now_ms, finger_present, motion_seen, woke_on_timer,
    input  ready
  );
  modport sink (
    input  valid, command, now_ms, finger_present, motion_seen, woke_on_timer,
    output ready
  );
endinterface

/* hw/rtl/wpsm_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpsm_out_if: status channel of the wearable power state machine
// Valid/ready channel carrying one status word per handshake.
// ----------------------------------------------------------------------------
interface wpsm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] power_state;
  logic       sensor_awake;

  modport source (output valid, power_state, sensor_awake, input ready);
  modport sink   (input valid, power_state, sensor_awake, output ready);
endinterface

/* hw/rtl/wearable_power_state_machine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wearable_power_state_machine_unit: three-mode sensor power manager
// Tracks finger and motion times, runs duty-cycled finger probe windows in
// idle and drops to dormant after a stillness timeout when allowed.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            word
//  in_ch     in   valid/ready          command, now_ms, finger/motion/woke flags
//  out_ch    out  valid/ready          power_state, sensor_awake
//  cfg_*     in   cfg_we (no ready)    cfg_index, cfg_wdata
//
//  One command word per cycle sustained while out_ch.ready stays high. A word
//  accepted sits in the input register, is applied to the state and lands in
//  the output register, where its status word waits to be taken.
//  Reset (rst_n low, synchronous) puts the block in idle, probe off, all time
//  stamps 0 and the registers at their default values.
//  A stalled output holds its word; the input register takes one more word
//  behind it, and in_ch.ready drops only while both registers are full and
//  out_ch.ready is low.
// ----------------------------------------------------------------------------
module wearable_power_state_machine_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  wpsm_in_if.sink                        in_ch,
  wpsm_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [wpsm_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [wpsm_pkg::CfgDataW-1:0]  cfg_wdata
);
  import wpsm_pkg::*;

  // configuration registers
  logic              dormant_allowed_r;
  logic [TimeW-1:0]  no_finger_timeout_r;
  logic [TimeW-1:0]  still_timeout_r;
  logic [CountW-1:0] probe_window_len_r;
  logic [TimeW-1:0]  probe_interval_r;

  // input stage
  logic              s1_valid_r;
  logic [1:0]        s1_command_r;
  logic [TimeW-1:0]  s1_now_r;
  logic              s1_finger_r;
  logic              s1_motion_r;
  logic              s1_woke_r;

  // power state
  mode_t             mode_r, mode_nxt;
  logic              probe_active_r, probe_active_nxt;
  logic [CountW-1:0] probe_count_r, probe_count_nxt;
  logic [TimeW-1:0]  last_finger_r, last_finger_nxt;
  logic [TimeW-1:0]  last_motion_r, last_motion_nxt;
  logic [TimeW-1:0]  phase_start_r, phase_start_nxt;

  // output stage
  logic              out_valid_r;
  mode_t             out_state_r;
  logic              out_awake_r;
  logic              awake_nxt;

  logic              advance;
  logic              fire;
  logic              in_ready;
  logic [CountW-1:0] count_inc;

  assign advance  = !out_valid_r || out_ch.ready;
  assign fire     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.power_state  = out_state_r;
  assign out_ch.sensor_awake = out_awake_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dormant_allowed_r   <= 1'b0;
      no_finger_timeout_r <= RST_NO_FINGER_TIMEOUT;
      still_timeout_r     <= RST_STILL_TIMEOUT;
      probe_window_len_r  <= RST_PROBE_WINDOW_LEN;
      probe_interval_r    <= RST_PROBE_INTERVAL;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DORMANT_ALLOWED:   dormant_allowed_r   <= cfg_wdata[0];
        CFG_NO_FINGER_TIMEOUT: no_finger_timeout_r <= cfg_wdata[TimeW-1:0];
        CFG_STILL_TIMEOUT:     still_timeout_r     <= cfg_wdata[TimeW-1:0];
        CFG_PROBE_WINDOW_LEN:  probe_window_len_r  <= cfg_wdata[CountW-1:0];
        CFG_PROBE_INTERVAL:    probe_interval_r    <= cfg_wdata[TimeW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_command_r <= in_ch.command;
      s1_now_r     <= in_ch.now_ms;
      s1_finger_r  <= in_ch.finger_present;
      s1_motion_r  <= in_ch.motion_seen;
      s1_woke_r    <= in_ch.woke_on_timer;
    end
  end

  assign count_inc = (probe_count_r == PROBE_COUNT_MAX) ? probe_count_r
                                                        : probe_count_r + 1'b1;

  // next state for the word in the input register
  always_comb begin
    mode_nxt         = mode_r;
    probe_active_nxt = probe_active_r;
    probe_count_nxt  = probe_count_r;
    last_finger_nxt  = last_finger_r;
    last_motion_nxt  = last_motion_r;
    phase_start_nxt  = phase_start_r;

    case (s1_command_r)
      CMD_START: begin
        mode_nxt         = MODE_IDLE;
        last_finger_nxt  = s1_now_r;
        last_motion_nxt  = s1_woke_r ? s1_now_r - still_timeout_r : s1_now_r;
        probe_active_nxt = 1'b1;
        probe_count_nxt  = '0;
        phase_start_nxt  = s1_now_r;
      end
      CMD_TICK: begin
        if (s1_motion_r) last_motion_nxt = s1_now_r;
        if (s1_finger_r) last_finger_nxt = s1_now_r;
        case (mode_r)
          MODE_MONITORING: begin
            if (s1_now_r - last_finger_nxt >= no_finger_timeout_r) begin
              mode_nxt         = MODE_IDLE;
              probe_active_nxt = 1'b0;
              probe_count_nxt  = '0;
              phase_start_nxt  = s1_now_r;
            end
          end
          MODE_IDLE: begin
            if (probe_active_r && s1_finger_r) begin
              // finger found during the probe: back to monitoring, count kept
              mode_nxt         = MODE_MONITORING;
              probe_active_nxt = 1'b0;
            end else begin
              if (probe_active_r) begin
                probe_count_nxt = count_inc;
                if (count_inc >= probe_window_len_r) begin
                  probe_active_nxt = 1'b0;
                  phase_start_nxt  = s1_now_r;
                end
              end else if (s1_now_r - phase_start_r >= probe_interval_r) begin
                probe_active_nxt = 1'b1;
                probe_count_nxt  = '0;
              end
              if (dormant_allowed_r && !probe_active_nxt &&
                  (s1_now_r - last_motion_nxt >= still_timeout_r)) begin
                mode_nxt = MODE_DORMANT;
              end
            end
          end
          default: ;
        endcase
      end
      CMD_CANCEL: begin
        mode_nxt         = MODE_IDLE;
        last_motion_nxt  = s1_now_r;
        probe_active_nxt = 1'b0;
        probe_count_nxt  = '0;
        phase_start_nxt  = s1_now_r;
      end
      default: ;  // unused code: drop the command, report current state
    endcase

    case (mode_nxt)
      MODE_MONITORING: awake_nxt = 1'b1;
      MODE_IDLE:       awake_nxt = probe_active_nxt;
      default:         awake_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_IDLE;
      probe_active_r <= 1'b0;
      probe_count_r  <= '0;
      last_finger_r  <= '0;
      last_motion_r  <= '0;
      phase_start_r  <= '0;
    end else if (fire) begin
      mode_r         <= mode_nxt;
      probe_active_r <= probe_active_nxt;
      probe_count_r  <= probe_count_nxt;
      last_finger_r  <= last_finger_nxt;
      last_motion_r  <= last_motion_nxt;
      phase_start_r  <= phase_start_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_state_r <= mode_nxt;
      out_awake_r <= awake_nxt;
    end
  end

  // dormant is only entered with the probe closed, and stays closed there
  a_dormant_probe_off: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_DORMANT |-> !probe_active_r)
    else $error("probe window open in dormant");

  // dormant only leaves to idle
  a_dormant_exit: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_DORMANT |=> (mode_r == MODE_DORMANT || mode_r == MODE_IDLE))
    else $error("dormant left to a mode other than idle");

  // a word in the input register moves on when the output slot is empty
  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_valid_r |=> out_valid_r)
    else $error("input word not advanced into empty output slot");

  // a reported awake sensor never goes with dormant
  a_awake_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_awake_r |-> out_state_r != MODE_DORMANT)
    else $error("sensor awake reported in dormant");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the wearable power state machine unit
// Drives command words over the valid/ready channel with random gaps and
// stalls. A scoreboard predicts the status word of each command and checks
// the returned words in order. Register settings change between phases.
// ----------------------------------------------------------------------------
module tb;
  import wpsm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE_LO = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE_HI = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_WORDS = 1350;
  localparam int unsigned HOLD_CYCLES = 60;

  typedef struct {
    logic [1:0] power_state;
    logic       sensor_awake;
  } status_t;

  class power_scoreboard;
    bit          dormant_ok;
    logic [31:0] finger_to;
    logic [31:0] still_to;
    logic [7:0]  window_len;
    logic [31:0] probe_gap;

    mode_t       cur_mode;
    bit          probing;
    logic [7:0]  probe_cnt;
    logic [31:0] finger_stamp;
    logic [31:0] motion_stamp;
    logic [31:0] phase_stamp;

    status_t     expected_status[$];
    int unsigned mismatches;

    function new();
      dormant_ok   = 1'b0;
      finger_to    = RST_NO_FINGER_TIMEOUT;
      still_to     = RST_STILL_TIMEOUT;
      window_len   = RST_PROBE_WINDOW_LEN;
      probe_gap    = RST_PROBE_INTERVAL;
      cur_mode     = MODE_IDLE;
      probing      = 1'b0;
      probe_cnt    = '0;
      finger_stamp = '0;
      motion_stamp = '0;
      phase_stamp  = '0;
      mismatches   = 0;
    endfunction

    function void load_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_DORMANT_ALLOWED:   dormant_ok = data[0];
        CFG_NO_FINGER_TIMEOUT: finger_to  = data;
        CFG_STILL_TIMEOUT:     still_to   = data;
        CFG_PROBE_WINDOW_LEN:  window_len = data[7:0];
        CFG_PROBE_INTERVAL:    probe_gap  = data;
        default: ;
      endcase
    endfunction

    function void tick_update(logic [31:0] now, bit finger, bit motion);
      if (motion) motion_stamp = now;
      if (finger) finger_stamp = now;
      case (cur_mode)
        MODE_MONITORING: begin
          if (now - finger_stamp >= finger_to) begin
            cur_mode    = MODE_IDLE;
            probing     = 1'b0;
            probe_cnt   = '0;
            phase_stamp = now;
          end
        end
        MODE_IDLE: begin
          if (probing) begin
            // a finger seen during a probe ends idle at once
            if (finger) begin
              cur_mode = MODE_MONITORING;
              probing  = 1'b0;
              return;
            end
            if (probe_cnt < PROBE_COUNT_MAX) probe_cnt++;
            if (probe_cnt >= window_len) begin
              probing     = 1'b0;
              phase_stamp = now;
            end
          end else if (now - phase_stamp >= probe_gap) begin
            probing   = 1'b1;
            probe_cnt = '0;
          end
          if (dormant_ok && !probing && (now - motion_stamp >= still_to))
            cur_mode = MODE_DORMANT;
        end
        default: ;
      endcase
    endfunction

    function void note_command(logic [1:0] cmd, logic [31:0] now, bit finger,
                               bit motion, bit woke);
      status_t want;
      case (cmd)
        CMD_START: begin
          cur_mode     = MODE_IDLE;
          finger_stamp = now;
          motion_stamp = woke ? now - still_to : now;
          probing      = 1'b1;
          probe_cnt    = '0;
          phase_stamp  = now;
        end
        CMD_TICK: tick_update(now, finger, motion);
        CMD_CANCEL: begin
          cur_mode     = MODE_IDLE;
          motion_stamp = now;
          probing      = 1'b0;
          probe_cnt    = '0;
          phase_stamp  = now;
        end
        default: ;
      endcase
      want.power_state  = cur_mode;
      want.sensor_awake = (cur_mode == MODE_MONITORING) ||
                          (cur_mode == MODE_IDLE && probing);
      expected_status.push_back(want);
    endfunction

    function void check_status(logic [1:0] state, logic awake);
      status_t want;
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected status word: state %0d awake %0d", state, awake);
        return;
      end
      want = expected_status.pop_front();
      if (state !== want.power_state || awake !== want.sensor_awake) begin
        mismatches++;
        if (mismatches <= 10)
          $display("status mismatch: expected state %0d awake %0d, got state %0d awake %0d",
                   want.power_state, want.sensor_awake, state, awake);
      end
    endfunction

    function int unsigned pending();
      return expected_status.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [31:0]        cfg_wdata;

  wpsm_in_if  in_ch ();
  wpsm_out_if out_ch ();

  wearable_power_state_machine_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  power_scoreboard sb;
  bit              quiet = 1'b0;
  int unsigned     hold_requests = 0;
  int unsigned     words_sent = 0;
  int unsigned     cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("wearable_power_state_machine_unit verification failed");
      $finish;
    end
  end

  // Status receiver: random stalls, plus a long hold-off when requested.
  initial begin
    int unsigned hold_left;
    int unsigned hold_served;
    hold_left = 0;
    hold_served = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_status(out_ch.power_state, out_ch.sensor_awake);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = quiet || ($urandom_range(99) >= 26);
      end
    end
  end

  task automatic set_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    sb.load_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_word(logic [1:0] cmd, logic [31:0] now, bit finger, bit motion,
                           bit woke);
    while (!quiet && $urandom_range(99) < 26) begin
      @(negedge clk);
      in_ch.valid          = 1'b0;
      in_ch.command        = 2'($urandom_range(3));
      in_ch.now_ms         = $urandom;
      in_ch.finger_present = 1'($urandom_range(1));
      in_ch.motion_seen    = 1'($urandom_range(1));
      in_ch.woke_on_timer  = 1'($urandom_range(1));
    end
    @(negedge clk);
    in_ch.valid          = 1'b1;
    in_ch.command        = cmd;
    in_ch.now_ms         = now;
    in_ch.finger_present = finger;
    in_ch.motion_seen    = motion;
    in_ch.woke_on_timer  = woke;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(cmd, now, finger, motion, woke);
    if (cmd != CMD_UNUSED) words_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Hold until every status word is back, then let the pipeline settle.
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_time(int unsigned small_max);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(small_max, 1);
    if (r < 88) return $urandom_range(4, 1);
    if (r < 96) return $urandom;
    return 32'hFFFF_FFFF;
  endfunction

  function automatic logic [31:0] next_time(logic [31:0] now);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return now;
    if (r < 80) return now + $urandom_range(40, 1);
    if (r < 95) return now + $urandom_range(600, 40);
    if (r < 97) return now + $urandom_range(400000, 600);
    // step back by one: elapsed times reach the all-ones value
    if (r < 98) return now - 32'd1;
    return $urandom;
  endfunction

  initial begin
    logic [31:0] now;
    logic [1:0]  cmd;
    int unsigned rand_goal;
    int unsigned phase;
    int unsigned n;
    int unsigned finger_pct;
    int unsigned motion_pct;
    int unsigned r;

    sb = new();
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.command        = CMD_TICK;
    in_ch.now_ms         = '0;
    in_ch.finger_present = 1'b0;
    in_ch.motion_seen    = 1'b0;
    in_ch.woke_on_timer  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, default registers: probe cycle, monitoring entry/exit,
    // unused command, wraparound stamps, start woken by timer, cancel.
    send_word(CMD_TICK, 32'd0, 1'b0, 1'b0, 1'b0);
    send_word(CMD_TICK, 32'd2000, 1'b0, 1'b1, 1'b0);
    send_word(CMD_TICK, 32'd2001, 1'b0, 1'b0, 1'b0);
    send_word(CMD_TICK, 32'd2002, 1'b1, 1'b0, 1'b0);
    send_word(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
    send_word(CMD_TICK, 32'd32002, 1'b0, 1'b0, 1'b0);
    send_word(CMD_START, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
    send_word(CMD_TICK, 32'd0, 1'b1, 1'b0, 1'b0);
    send_word(CMD_CANCEL, 32'd5, 1'b1, 1'b1, 1'b1);
    send_word(CMD_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
    for (int i = 0; i < 5; i++) send_word(CMD_TICK, i, 1'b0, 1'b0, 1'b0);
    release_input();
    wait_drained();

    // Zero timeouts and window length: every transition fires at first chance.
    set_reg(CFG_DORMANT_ALLOWED, 32'hFFFF_FFFF);
    set_reg(CFG_NO_FINGER_TIMEOUT, 32'd0);
    set_reg(CFG_STILL_TIMEOUT, 32'd0);
    set_reg(CFG_PROBE_WINDOW_LEN, 32'hFFFF_FF00);
    set_reg(CFG_PROBE_INTERVAL, 32'd0);
    set_reg(CFG_IDX_SPARE_LO, $urandom);
    set_reg(CFG_IDX_SPARE_HI, $urandom);
    send_word(CMD_TICK, 32'd100, 1'b0, 1'b0, 1'b0);
    send_word(CMD_TICK, 32'd100, 1'b0, 1'b0, 1'b0);
    send_word(CMD_TICK, 32'd101, 1'b1, 1'b1, 1'b0);
    send_word(CMD_START, 32'd7, 1'b0, 1'b0, 1'b0);
    send_word(CMD_TICK, 32'd7, 1'b1, 1'b0, 1'b0);
    send_word(CMD_TICK, 32'd8, 1'b0, 1'b0, 1'b0);
    send_word(CMD_CANCEL, 32'd0, 1'b0, 1'b0, 1'b0);
    send_word(CMD_TICK, 32'd0, 1'b0, 1'b0, 1'b0);
    release_input();

    rand_goal = words_sent + RANDOM_WORDS;
    phase = 0;
    now = $urandom;
    while (words_sent < rand_goal) begin
      wait_drained();
      case (phase)
        2: begin
          set_reg(CFG_DORMANT_ALLOWED, 32'd1);
          set_reg(CFG_NO_FINGER_TIMEOUT, 32'd1);
          set_reg(CFG_STILL_TIMEOUT, 32'd1);
          set_reg(CFG_PROBE_WINDOW_LEN, 32'd1);
          set_reg(CFG_PROBE_INTERVAL, 32'd1);
        end
        4: begin
          set_reg(CFG_DORMANT_ALLOWED, 32'd1);
          set_reg(CFG_NO_FINGER_TIMEOUT, 32'hFFFF_FFFF);
          set_reg(CFG_STILL_TIMEOUT, 32'hFFFF_FFFF);
          set_reg(CFG_PROBE_WINDOW_LEN, 32'd255);
          set_reg(CFG_PROBE_INTERVAL, 32'hFFFF_FFFF);
        end
        5: begin
          // long probe windows: count all the way up to the top
          set_reg(CFG_DORMANT_ALLOWED, 32'd0);
          set_reg(CFG_PROBE_WINDOW_LEN, 32'd255);
          set_reg(CFG_PROBE_INTERVAL, $urandom_range(20, 1));
        end
        default: begin
          if ($urandom_range(99) < 70) set_reg(CFG_DORMANT_ALLOWED, $urandom);
          if ($urandom_range(99) < 70) set_reg(CFG_NO_FINGER_TIMEOUT, pick_time(400));
          if ($urandom_range(99) < 70) set_reg(CFG_STILL_TIMEOUT, pick_time(1500));
          if ($urandom_range(99) < 70)
            set_reg(CFG_PROBE_WINDOW_LEN, {$urandom_range(255) << 8} | $urandom_range(10, 1));
          if ($urandom_range(99) < 70) set_reg(CFG_PROBE_INTERVAL, pick_time(200));
          if ($urandom_range(99) < 10)
            set_reg(CfgIdxW'($urandom_range(7, 5)), $urandom);
        end
      endcase
      quiet = (phase == 1 || phase == 3);
      if (phase == 3) hold_requests++;
      if (phase % 4 == 0) now = 32'hFFFF_FFFF - $urandom_range(3000);
      n = (phase == 5) ? 300 : $urandom_range(120, 40);
      finger_pct = (phase == 5) ? 0 : $urandom_range(40);
      motion_pct = $urandom_range(30);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(99);
        if (r < 85) cmd = CMD_TICK;
        else if (r < 91) cmd = CMD_START;
        else if (r < 96) cmd = CMD_CANCEL;
        else cmd = CMD_UNUSED;
        now = (phase == 5) ? now + $urandom_range(3) : next_time(now);
        send_word(cmd, now, $urandom_range(99) < finger_pct,
                  $urandom_range(99) < motion_pct, 1'($urandom_range(1)));
      end
      release_input();
      quiet = 1'b0;
      phase++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("wearable_power_state_machine_unit verification clean");
    end else begin
      $display("wearable_power_state_machine_unit verification failed");
    end
    $finish;
  end
endmodule
